@@ hw/rtl/slr_pkg.sv @@
// Package for the stereo linear resampler: word types, controller/datapath
// command and status structs, register indexes and sizing constants.
// No dependencies.
package slr_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_INDEX_BITS  = 32;
  localparam int STEP_BITS       = 23;
  localparam int LIMIT_BITS      = 32;
  localparam int CFG_DATA_BITS   = 32;
  localparam int MAX_RESULTS     = 64;
  localparam int CNT_BITS        = $clog2(MAX_RESULTS + 1);

  localparam logic REG_PHASE_STEP  = 1'b0;
  localparam logic REG_FRAME_LIMIT = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          last_frame;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          sample_valid;
    logic                          stream_end;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic mult;
    logic jump;
    logic blend;
    logic commit;
    logic set_ended;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic finished;
    logic have_prev;
    logic last;
    logic ended;
    logic at_end;
    logic limit_hit;
    logic cnt_full;
    logic hold_valid;
    logic out_free;
  } ctl_stat_t;

endpackage

@@ hw/rtl/slr_ctrl.sv @@
// Sequencing controller of the stereo linear resampler.
// Depends on slr_pkg; drives the datapath through ctl_cmd_t, reads ctl_stat_t.
module slr_ctrl
  import slr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ctl_stat_t stat_i,
  output ctl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BLEND,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   sweep2_q, sweep2_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    sweep2_d = sweep2_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          sweep2_d     = 1'b0;
          if (stat_i.finished) begin
            state_d = ST_IDLE;
          end else if (stat_i.have_prev) begin
            state_d = ST_CHECK;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_CHECK: begin
        if (stat_i.at_end) begin
          state_d = sweep2_q ? ST_FINISH : ST_COMMIT;
        end else if (stat_i.limit_hit) begin
          cmd_o.set_ended = 1'b1;
          state_d = sweep2_q ? ST_FINISH : ST_COMMIT;
        end else if (stat_i.cnt_full) begin
          cmd_o.jump = 1'b1;
          state_d = sweep2_q ? ST_FINISH : ST_COMMIT;
        end else begin
          cmd_o.mult = 1'b1;
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (!stat_i.hold_valid || stat_i.out_free) begin
          cmd_o.blend = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit    = 1'b1;
        cmd_o.set_ended = stat_i.last | stat_i.limit_hit;
        if (stat_i.last && !stat_i.ended) begin
          sweep2_d = 1'b1;
          state_d  = ST_CHECK;
        end else begin
          state_d  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sweep2_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep2_q <= sweep2_d;
    end
  end

endmodule

@@ hw/rtl/slr_datapath.sv @@
// Datapath of the stereo linear resampler: frame and position state,
// blend multipliers, pending-sample and output registers, config registers.
// Depends on slr_pkg; commanded by slr_ctrl.
module slr_datapath
  import slr_pkg::*;
#(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  in_word_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_data_o,
  input  ctl_cmd_t                 cmd_i,
  output ctl_stat_t                stat_o
);

  localparam int POS_BITS  = INDEX_BITS + FRAC_BITS;
  localparam int LIM_W     = (INDEX_BITS > LIMIT_BITS) ? INDEX_BITS : LIMIT_BITS;
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

  logic [STEP_BITS-1:0]  phase_step_q;
  logic [LIMIT_BITS-1:0] frame_limit_q;

  logic                  have_prev_q, finished_q, ended_q, last_q, sel_cur_q;
  logic [INDEX_BITS-1:0] frame_index_q;
  logic [POS_BITS-1:0]   pos_q;
  logic [INDEX_BITS:0]   end_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  hold_valid_q, out_valid_q;

  logic signed [SAMPLE_BITS-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic signed [SAMPLE_BITS-1:0] hold_l_q, hold_r_q;
  logic signed [PROD_BITS-1:0]   prod_l_q, prod_r_q;
  out_word_t                     out_q;

  logic [INDEX_BITS-1:0]         pos_int;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [SAMPLE_BITS-1:0] a_l, a_r;
  logic signed [DIFF_BITS-1:0]   diff_l, diff_r;
  logic signed [PROD_BITS-1:0]   sum_l, sum_r;
  logic [STEP_BITS-1:0]          step_eff;
  logic                          out_free;

  assign pos_int  = pos_q[POS_BITS-1:FRAC_BITS];
  assign frac_s   = signed'({1'b0, pos_q[FRAC_BITS-1:0]});
  assign a_l      = sel_cur_q ? cur_l_q : prev_l_q;
  assign a_r      = sel_cur_q ? cur_r_q : prev_r_q;
  assign diff_l   = DIFF_BITS'(cur_l_q) - DIFF_BITS'(a_l);
  assign diff_r   = DIFF_BITS'(cur_r_q) - DIFF_BITS'(a_r);
  assign sum_l    = PROD_BITS'(a_l) + (prod_l_q >>> FRAC_BITS);
  assign sum_r    = PROD_BITS'(a_r) + (prod_r_q >>> FRAC_BITS);
  assign step_eff = (phase_step_q == '0) ? STEP_BITS'(1) : phase_step_q;
  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.finished   = finished_q;
  assign stat_o.have_prev  = have_prev_q;
  assign stat_o.last       = last_q;
  assign stat_o.ended      = ended_q;
  assign stat_o.at_end     = {1'b0, pos_int} >= end_q;
  assign stat_o.limit_hit  = (frame_limit_q != '0) && (LIM_W'(pos_int) >= LIM_W'(frame_limit_q));
  assign stat_o.cnt_full   = cnt_q >= CNT_BITS'(MAX_RESULTS);
  assign stat_o.hold_valid = hold_valid_q;
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= STEP_BITS'(65536);
      frame_limit_q <= '0;
      have_prev_q   <= 1'b0;
      finished_q    <= 1'b0;
      ended_q       <= 1'b0;
      last_q        <= 1'b0;
      sel_cur_q     <= 1'b0;
      frame_index_q <= '0;
      pos_q         <= '0;
      end_q         <= '0;
      cnt_q         <= '0;
      hold_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      prev_l_q      <= '0;
      prev_r_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PHASE_STEP:  phase_step_q  <= cfg_data_i[STEP_BITS-1:0];
          REG_FRAME_LIMIT: frame_limit_q <= cfg_data_i[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if ((cmd_i.blend && hold_valid_q) || (cmd_i.flush && (hold_valid_q || ended_q))) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.accept) begin
        last_q    <= in_data_i.last_frame;
        ended_q   <= 1'b0;
        cnt_q     <= '0;
        sel_cur_q <= 1'b0;
        end_q     <= {1'b0, frame_index_q};
      end
      if (cmd_i.mult) begin
        pos_q <= pos_q + POS_BITS'(step_eff);
        cnt_q <= cnt_q + CNT_BITS'(1);
      end
      if (cmd_i.jump) begin
        pos_q <= {end_q[INDEX_BITS-1:0], {FRAC_BITS{1'b0}}};
      end
      if (cmd_i.blend) begin
        hold_valid_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        prev_l_q      <= cur_l_q;
        prev_r_q      <= cur_r_q;
        have_prev_q   <= 1'b1;
        frame_index_q <= frame_index_q + INDEX_BITS'(1);
        end_q         <= {1'b0, frame_index_q} + (INDEX_BITS + 1)'(1);
        sel_cur_q     <= 1'b1;
      end
      if (cmd_i.set_ended) begin
        ended_q <= 1'b1;
      end
      if (cmd_i.flush) begin
        hold_valid_q <= 1'b0;
        finished_q   <= finished_q | ended_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_l_q <= in_data_i.left_in;
      cur_r_q <= in_data_i.right_in;
    end
    if (cmd_i.mult) begin
      prod_l_q <= PROD_BITS'(diff_l * frac_s);
      prod_r_q <= PROD_BITS'(diff_r * frac_s);
    end
    if (cmd_i.blend) begin
      hold_l_q <= sum_l[SAMPLE_BITS-1:0];
      hold_r_q <= sum_r[SAMPLE_BITS-1:0];
      if (hold_valid_q) begin
        out_q <= '{left_out: hold_l_q, right_out: hold_r_q,
                   sample_valid: 1'b1, stream_end: 1'b0};
      end
    end
    if (cmd_i.flush) begin
      if (hold_valid_q) begin
        out_q <= '{left_out: hold_l_q, right_out: hold_r_q,
                   sample_valid: 1'b1, stream_end: ended_q};
      end else if (ended_q) begin
        out_q <= '{left_out: '0, right_out: '0, sample_valid: 1'b0, stream_end: 1'b1};
      end
    end
  end

endmodule

@@ hw/rtl/stereo_linear_resampler_core.sv @@
// Stereo linear-interpolation resampler core: top level joining the
// controller and the datapath. Depends on slr_pkg, slr_ctrl, slr_datapath.
//
// Input channel in_valid_i/in_stall_o/in_data_i carries one stereo source
// frame per word, last_frame on the final one. Output channel
// out_valid_o/out_stall_i/out_data_o carries interpolated samples; the final
// word of the stream has stream_end set, and a word with sample_valid low is
// a bare end mark. Config: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 phase_step, 1 frame_limit) at the clock edge; write only while idle.
// One frame is worked at a time. Every sample is a multiply step and an add
// step on one shared multiplier per channel; every sweep ends with an end
// check, and a commit and a flush close the frame. A sample passes from the
// product register to the pending register and then to the output register.
// While the receiver stalls, the output register holds its word, one finished
// sample waits in a pending register, and the sweep waits; a frame is
// accepted again once the flush is done.
// Reset clears position, frame index, previous frame and the end state and
// sets phase_step to 1.0; after the end of the stream, frames are accepted
// and dropped until reset.
module stereo_linear_resampler_core
  import slr_pkg::*;
#(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_word_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_data_o
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  slr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  slr_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

@@ hw/rtl/slr_checker.sv @@
// Port-level assertions for the stereo linear resampler core, bound to the
// top level. Depends on slr_pkg and stereo_linear_resampler_core.
module slr_checker
  import slr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  logic end_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && out_data_o.stream_end) begin
      end_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_bare_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sample_valid |-> out_data_o.stream_end)
    else $error("word without sample lacks end mark");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sample_valid |->
      out_data_o.left_out == '0 && out_data_o.right_out == '0)
    else $error("bare end mark carries sample data");

  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_seen_q |-> !out_valid_o)
    else $error("output after end of stream");

endmodule

bind stereo_linear_resampler_core slr_checker u_slr_checker (.*);

@@ dv/slr_sample_book_pkg.sv @@
// Scoreboard for the stereo linear resampler testbench: predicts the output
// words of every accepted source frame and checks the words the core emits.
// Depends on slr_pkg.
package slr_sample_book_pkg;
  import slr_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;

  class resample_book;
    logic [STEP_BITS-1:0]  step_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    longint                prev_l;
    longint                prev_r;
    bit                    have_prev;
    logic [31:0]           frame_idx;
    logic [47:0]           read_pos;
    bit                    finished;
    int                    emitted;
    int                    errors;
    int                    checked;
    out_word_t             expect_q[$];

    function new();
      step_reg  = STEP_BITS'(32'h10000);
      limit_reg = '0;
      prev_l    = 0;
      prev_r    = 0;
      have_prev = 0;
      frame_idx = '0;
      read_pos  = '0;
      finished  = 0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void load_reg(logic idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_PHASE_STEP) begin
        step_reg = data[STEP_BITS-1:0];
      end else begin
        limit_reg = data[LIMIT_BITS-1:0];
      end
    endfunction

    function longint blend(longint a, longint b, longint unsigned frac);
      longint p;
      p = (b - a) * longint'(frac);
      return a + (p >>> FRAC);
    endfunction

    function void push(longint l, longint r, bit has_sample);
      out_word_t w;
      w.left_out     = l[SAMPLE_BITS-1:0];
      w.right_out    = r[SAMPLE_BITS-1:0];
      w.sample_valid = has_sample;
      w.stream_end   = 1'b0;
      expect_q.push_back(w);
      emitted++;
    endfunction

    // emit positions whose integer part lies below stop until the limit or MAX_RESULTS; 1 if the limit hit
    function bit sweep(longint unsigned stop, longint al, longint ar, longint bl, longint br);
      longint unsigned whole;
      longint unsigned frac;
      logic [47:0]     step_eff;
      bit              hit;
      bit              busy;
      step_eff = (step_reg == '0) ? 48'd1 : 48'(step_reg);
      hit = 0;
      busy = 1;
      while (busy) begin
        whole = 64'(read_pos >> FRAC);
        frac  = 64'(read_pos[FRAC-1:0]);
        if (whole >= stop) begin
          busy = 0;
        end else if (limit_reg != '0 && whole >= 64'(limit_reg)) begin
          hit = 1;
          busy = 0;
        end else if (emitted >= MAX_RESULTS) begin
          read_pos = 48'(stop << FRAC);
          busy = 0;
        end else begin
          push(blend(al, bl, frac), blend(ar, br, frac), 1'b1);
          read_pos = read_pos + step_eff;
        end
      end
      return hit;
    endfunction

    function void note_frame(in_word_t w);
      longint      cl;
      longint      cr;
      bit          ended;
      logic [31:0] n;
      out_word_t   tail;
      if (finished) return;
      cl = $signed(w.left_in);
      cr = $signed(w.right_in);
      n = frame_idx;
      emitted = 0;
      ended = 0;
      if (have_prev) ended = sweep(64'(n), prev_l, prev_r, cl, cr);
      prev_l = cl;
      prev_r = cr;
      have_prev = 1;
      frame_idx = n + 32'd1;
      if (!ended && w.last_frame) begin
        void'(sweep(64'(n) + 64'd1, cl, cr, cl, cr));
        ended = 1;
      end
      if (!ended && limit_reg != '0 && (read_pos >> FRAC) >= 48'(limit_reg)) ended = 1;
      if (ended) begin
        finished = 1;
        if (emitted == 0) push(0, 0, 1'b0);
        tail = expect_q.pop_back();
        tail.stream_end = 1'b1;
        expect_q.push_back(tail);
      end
    endfunction

    task report(string what);
      $display("%0t ns  mismatch: %s", $time, what);
      errors++;
    endtask

    task check_sample(out_word_t got);
      out_word_t want;
      if (expect_q.size() == 0) begin
        report($sformatf("unexpected word l=%0d r=%0d sv=%0b end=%0b",
                         got.left_out, got.right_out, got.sample_valid, got.stream_end));
        return;
      end
      want = expect_q.pop_front();
      checked++;
      if (got.left_out !== want.left_out)
        report($sformatf("word %0d left_out %0d, want %0d", checked, got.left_out,
                         want.left_out));
      if (got.right_out !== want.right_out)
        report($sformatf("word %0d right_out %0d, want %0d", checked, got.right_out,
                         want.right_out));
      if (got.sample_valid !== want.sample_valid)
        report($sformatf("word %0d sample_valid %0b, want %0b", checked, got.sample_valid,
                         want.sample_valid));
      if (got.stream_end !== want.stream_end)
        report($sformatf("word %0d stream_end %0b, want %0b", checked, got.stream_end,
                         want.stream_end));
    endtask
  endclass

endpackage

@@ dv/stereo_linear_resampler_core_tb.sv @@
// Testbench for stereo_linear_resampler_core: drives one long stream of
// stereo frames through several step and limit settings with random idling.
// Depends on slr_pkg, slr_sample_book_pkg and the core RTL.
module stereo_linear_resampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slr_pkg::*;
  import slr_sample_book_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 200;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  in_word_t                 in_data_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  out_word_t                out_data_o;

  resample_book book = new();
  bit           calm;
  int           quiet;

  stereo_linear_resampler_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #4ns clk_i = ~clk_i;

  function automatic in_word_t frame_of(logic signed [SAMPLE_BITS-1:0] l,
                                        logic signed [SAMPLE_BITS-1:0] r, logic last);
    in_word_t w;
    w.left_in    = l;
    w.right_in   = r;
    w.last_frame = last;
    return w;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 5))
      3:       return S_MAX;
      4:       return S_MIN;
      5:       return SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic send_frame(in_word_t w);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    book.note_frame(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    book.load_reg(idx, data);
  endtask

  task automatic write_step(logic [STEP_BITS-1:0] step);
    write_reg(REG_PHASE_STEP, {9'($urandom_range(0, 511)), step});
  endtask

  // receiver: random stall, one long hold-off to back the core up
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) book.check_sample(out_data_o);
      @(negedge clk_i);
      if (!held && book.checked >= 150) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (!calm && $urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("** stereo_linear_resampler_core: FAILED **");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    logic [STEP_BITS-1:0]  step;
    logic [LIMIT_BITS-1:0] lim;
    int                    guard;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_PHASE_STEP;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: unit step, no limit
    send_frame(frame_of(S_MAX, S_MIN, 1'b0));
    send_frame(frame_of(S_MIN, S_MAX, 1'b0));
    send_frame(frame_of(24'sd0, -24'sd1, 1'b0));
    send_frame(frame_of(S_MAX, S_MAX, 1'b0));
    drain();

    // fine step, widest swings
    write_step(STEP_BITS'(2048));
    write_reg(REG_FRAME_LIMIT, 32'hFFFF_FFFF);
    send_frame(frame_of(S_MIN, S_MAX, 1'b0));
    send_frame(frame_of(S_MAX, S_MIN, 1'b0));
    send_frame(frame_of(S_MIN, S_MIN, 1'b0));
    send_frame(frame_of(-24'sd1, 24'sd0, 1'b0));
    send_frame(frame_of(24'sd1, -24'sd1, 1'b0));
    drain();

    // zero step: every frame overruns the per-frame budget
    write_step('0);
    send_frame(frame_of(S_MAX, S_MIN, 1'b0));
    send_frame(frame_of(S_MIN, S_MAX, 1'b0));
    send_frame(frame_of(24'sd0, 24'sd0, 1'b0));
    drain();

    write_step(STEP_BITS'(4194304));
    repeat (6) send_frame(frame_of(rand_sample(), rand_sample(), 1'b0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0:       step = STEP_BITS'(2048);
        1:       step = STEP_BITS'(4194304);
        2:       step = STEP_BITS'($urandom_range(2048, 16384));
        3:       step = STEP_BITS'($urandom_range(16384, 262144));
        4:       step = STEP_BITS'($urandom_range(2048, 4194304));
        default: step = STEP_BITS'($urandom_range(0, 1500));
      endcase
      if (ph == 0) lim = '0;
      else if (ph == 1) lim = 32'hFFFF_FFFF;
      else begin
        case ($urandom_range(0, 2))
          0:       lim = '0;
          1:       lim = 32'hFFFF_FFFF;
          default: lim = book.frame_idx + 32'($urandom_range(1000, 1 << 20));
        endcase
      end
      write_step(step);
      write_reg(REG_FRAME_LIMIT, lim);
      calm = (ph == 2);
      repeat (50) send_frame(frame_of(rand_sample(), rand_sample(), 1'b0));
      drain();
      calm = 1'b0;
    end

    // close the stream: last frame, bare end mark, or frame limit
    case ($urandom_range(0, 2))
      0: begin
        write_step(STEP_BITS'($urandom_range(8192, 65536)));
        repeat ($urandom_range(2, 6)) send_frame(frame_of(rand_sample(), rand_sample(), 1'b0));
        send_frame(frame_of(rand_sample(), rand_sample(), 1'b1));
      end
      1: begin
        write_step(STEP_BITS'(4194304));
        guard = 0;
        send_frame(frame_of(rand_sample(), rand_sample(), 1'b0));
        while ((book.read_pos >> FRAC) <= 48'(book.frame_idx) && guard < 200) begin
          send_frame(frame_of(rand_sample(), rand_sample(), 1'b0));
          guard++;
        end
        send_frame(frame_of(rand_sample(), rand_sample(), 1'b1));
      end
      default: begin
        write_step(STEP_BITS'($urandom_range(8192, 98304)));
        write_reg(REG_FRAME_LIMIT, 32'(book.read_pos >> FRAC) + 32'($urandom_range(2, 20)));
        guard = 0;
        while (!book.finished && guard < 200) begin
          send_frame(frame_of(rand_sample(), rand_sample(), 1'b0));
          guard++;
        end
      end
    endcase

    // frames after the end are taken and dropped
    repeat (4) send_frame(frame_of(rand_sample(), rand_sample(), 1'b1));
    drain();

    if (book.errors == 0 && book.expect_q.size() == 0) begin
      $display("** stereo_linear_resampler_core: PASSED **");
    end else begin
      $display("** stereo_linear_resampler_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/slr_pkg.sv
hw/rtl/slr_ctrl.sv
hw/rtl/slr_datapath.sv
hw/rtl/stereo_linear_resampler_core.sv
hw/rtl/slr_checker.sv
dv/slr_sample_book_pkg.sv
dv/stereo_linear_resampler_core_tb.sv
